[src/cfm_pkg.sv]
// ----------------------------------------------------------------------------
// cfm_pkg: shared types and constants of the chunked fetch master
// holds the item, result and config structs and the sequencer states
// ----------------------------------------------------------------------------
package cfm_pkg;

    localparam int MEM_BYTES       = 65536;
    localparam int MAX_FRAME_BYTES = 1024;
    localparam int LEN_W           = $clog2(MAX_FRAME_BYTES + 1);
    localparam int INFO_MIN_LEN    = 6;
    localparam int DATA_MIN_LEN    = 2;
    localparam int HDR_BYTES       = 6;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [1:0] REG_CAPACITY  = 2'd0;
    localparam logic [1:0] REG_THRESHOLD = 2'd1;
    localparam logic [1:0] REG_INFO_CMD  = 2'd2;
    localparam logic [1:0] REG_DATA_CMD  = 2'd3;

    localparam logic [16:0] RST_CAPACITY  = 17'd65536;
    localparam logic [7:0]  RST_THRESHOLD = 8'd30;
    localparam logic [7:0]  RST_INFO_CMD  = 8'd1;
    localparam logic [7:0]  RST_DATA_CMD  = 8'd2;

    typedef enum logic [1:0] {
        BS_RUN,
        BS_DIV,
        BS_MUL,
        BS_FIN
    } t_bstate;

    typedef struct packed {
        logic             op;
        logic [7:0]       frame_cmd;
        logic [LEN_W-1:0] len;
        logic [7:0]       byte_value;
        logic             byte_last;
    } t_item;

    typedef struct packed {
        logic [16:0] capacity;
        logic [7:0]  threshold;
        logic [7:0]  info_cmd;
        logic [7:0]  data_cmd;
    } t_cfg;

    typedef struct packed {
        logic        mem_write;
        logic        mem_bank;
        logic [15:0] mem_addr;
        logic [7:0]  mem_data;
        logic        tick_done;
        logic [7:0]  tx_cmd;
        logic [15:0] tx_index;
        logic        committed;
        logic        ready_valid;
        logic        ready_bank;
        logic [16:0] ready_size;
        logic [15:0] resync_total;
    } t_result;

endpackage

[src/cfm_front.sv]
// ----------------------------------------------------------------------------
// cfm_front: input side of the chunked fetch master
// takes input transactions, clamps the frame length and queues them
// ----------------------------------------------------------------------------
module cfm_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_op,
    input  logic [7:0]          i_frame_cmd,
    input  logic [15:0]         i_frame_len,
    input  logic [7:0]          i_byte_value,
    input  logic                i_byte_last,
    output logic                o_q_valid,
    output cfm_pkg::t_item      o_q_item,
    input  logic                i_q_pop
);
    import cfm_pkg::*;

    t_item       r_mem [QUEUE_DEPTH];
    logic        r_wp, n_wp, r_rp, n_rp;
    logic [1:0]  r_cnt, n_cnt;
    t_item       w_item;
    logic        w_push;

    always_comb begin
        w_item.op         = i_op;
        w_item.frame_cmd  = i_frame_cmd;
        // payload beyond the frame buffer is never used
        w_item.len        = (i_frame_len > 16'(MAX_FRAME_BYTES)) ?
                            LEN_W'(MAX_FRAME_BYTES) : i_frame_len[LEN_W-1:0];
        w_item.byte_value = i_byte_value;
        w_item.byte_last  = i_byte_last;
    end

    assign o_in_stall = (r_cnt == 2'(QUEUE_DEPTH));
    assign w_push     = i_in_valid && !o_in_stall;
    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q_item   = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp ^ w_push;
        n_rp  = r_rp ^ i_q_pop;
        n_cnt = r_cnt + 2'(w_push) - 2'(i_q_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= w_item;
        end
    end

endmodule

[src/cfm_div.sv]
// ----------------------------------------------------------------------------
// cfm_div: iterative divider
// restoring division, one quotient bit per cycle
// ----------------------------------------------------------------------------
module cfm_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [16:0] i_dividend,
    input  logic [15:0] i_divisor,
    output logic        o_done,
    output logic [16:0] o_quotient
);
    import cfm_pkg::*;

    logic [16:0] r_rem, n_rem;
    logic [16:0] r_quo, n_quo;
    logic [15:0] r_dvs;
    logic [4:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy, r_done, n_done;
    logic [16:0] w_trial;

    assign w_trial    = {r_rem[15:0], r_quo[16]};
    assign o_done     = r_done;
    assign o_quotient = r_quo;

    always_comb begin
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_rem  = 17'd0;
            n_quo  = i_dividend;
            n_cnt  = 5'd17;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_trial >= {1'b0, r_dvs}) begin
                n_rem = w_trial - {1'b0, r_dvs};
                n_quo = {r_quo[15:0], 1'b1};
            end else begin
                n_rem = w_trial;
                n_quo = {r_quo[15:0], 1'b0};
            end
            n_cnt = r_cnt - 5'd1;
            if (r_cnt == 5'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 5'd0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        if (i_start) begin
            r_dvs <= i_divisor;
        end
    end

endmodule

[src/cfm_back.sv]
// ----------------------------------------------------------------------------
// cfm_back: execution side of the chunked fetch master
// runs the fetch protocol on queued items and fills the result register
// ----------------------------------------------------------------------------
module cfm_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cfm_pkg::t_cfg     i_cfg,
    input  logic              i_q_valid,
    input  cfm_pkg::t_item    i_q_item,
    output logic              o_q_pop,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output cfm_pkg::t_result  o_res
);
    import cfm_pkg::*;

    t_bstate     r_st, n_st;
    logic        r_phase, r_ready, r_bank;
    logic [15:0] r_cb, r_cc, r_tb, r_wi, r_pos;
    logic [16:0] r_total, r_base;
    logic [7:0]  r_stall;
    logic [15:0] r_resync;
    logic [47:0] r_hdr;
    logic [31:0] r_prod;
    logic        r_out_valid, n_out_valid;
    t_result     r_out, n_res;

    logic        w_free, w_fire;
    logic [16:0] w_cap;
    logic [15:0] w_len;
    logic [47:0] w_hdr;
    logic        w_wcond, w_wr, w_tick, w_info_go, w_data_ok, w_commit, w_resync;
    logic [15:0] w_off, w_copy, w_lim, w_wi_inc, w_cb0, w_mx, w_ccn, w_tbn;
    logic [17:0] w_addr, w_base_inc;
    logic [7:0]  w_stall1;
    logic [32:0] w_tot;
    logic        w_div_done;
    logic [16:0] w_quo;

    cfm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_info_go && w_fire),
        .i_dividend (w_cap),
        .i_divisor  (w_cb0),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    assign w_free      = !r_out_valid || !i_out_stall;
    assign w_fire      = (r_st == BS_RUN) && i_q_valid && w_free;
    assign o_q_pop     = w_fire;
    assign o_out_valid = r_out_valid;
    assign o_res       = r_out;
    assign w_cap       = (i_cfg.capacity > 17'(MEM_BYTES)) ? 17'(MEM_BYTES) : i_cfg.capacity;
    assign w_len       = 16'(i_q_item.len);
    assign n_out_valid = (w_fire && !w_info_go) || (r_st == BS_FIN && w_free) ||
                         (r_out_valid && i_out_stall);

    always_comb begin
        w_hdr = (r_pos == 16'd0) ? 48'd0 : r_hdr;
        if (i_q_item.op && r_pos < w_len && r_pos < 16'(HDR_BYTES)) begin
            w_hdr[8*r_pos[2:0] +: 8] = i_q_item.byte_value;
        end
    end

    always_comb begin
        w_wcond   = i_q_item.op && r_phase && i_q_item.frame_cmd == i_cfg.data_cmd &&
                    r_pos >= 16'(DATA_MIN_LEN) && r_pos < w_len && w_hdr[15:0] == r_wi;
        w_off     = r_pos - 16'(DATA_MIN_LEN);
        w_lim     = (r_wi == r_cc - 16'd1) ? r_tb : r_cb;
        w_copy    = w_len - 16'(DATA_MIN_LEN);
        if (w_copy > w_lim) w_copy = w_lim;
        w_addr    = {1'b0, r_base} + {2'b0, w_off};
        w_wr      = w_wcond && w_off < w_copy && w_addr < {1'b0, w_cap};
        w_tick    = !i_q_item.op || i_q_item.byte_last;
        w_info_go = i_q_item.op && i_q_item.byte_last && !r_phase &&
                    i_q_item.frame_cmd == i_cfg.info_cmd && w_len >= 16'(INFO_MIN_LEN);
        w_data_ok = i_q_item.op && i_q_item.byte_last && r_phase &&
                    i_q_item.frame_cmd == i_cfg.data_cmd && w_len >= 16'(DATA_MIN_LEN) &&
                    w_hdr[15:0] == r_wi;
        w_wi_inc  = r_wi + 16'd1;
        w_commit  = w_data_ok && w_wi_inc >= r_cc;
        w_stall1  = (r_stall != 8'hFF) ? r_stall + 8'd1 : r_stall;
        w_resync  = w_tick && !w_info_go && !w_data_ok && w_stall1 >= i_cfg.threshold;
        w_base_inc = {1'b0, r_base} + {2'b0, r_cb};
        w_cb0     = (w_hdr[15:0] == 16'd0) ? 16'd1 : w_hdr[15:0];
        // clamp of the chunk count limit taken from the division
        if (w_quo == 17'd0)        w_mx = 16'd1;
        else if (w_quo[16])        w_mx = 16'hFFFF;
        else                       w_mx = w_quo[15:0];
        w_ccn     = (r_hdr[31:16] == 16'd0 || r_hdr[31:16] > w_mx) ? w_mx : r_hdr[31:16];
        w_tbn     = (r_hdr[47:32] == 16'd0 || r_hdr[47:32] > r_cb) ? r_cb : r_hdr[47:32];
        w_tot     = {1'b0, r_prod} + {17'd0, r_tb};
    end

    always_comb begin
        n_st = r_st;
        case (r_st)
            BS_RUN:  if (w_fire && w_info_go) n_st = BS_DIV;
            BS_DIV:  if (w_div_done) n_st = BS_MUL;
            BS_MUL:  n_st = BS_FIN;
            BS_FIN:  if (w_free) n_st = BS_RUN;
            default: n_st = BS_RUN;
        endcase
    end

    // result of the item being finished, from the state it leaves
    always_comb begin
        n_res              = r_out;
        n_res.mem_write    = 1'b0;
        n_res.mem_bank     = 1'b0;
        n_res.mem_addr     = 16'd0;
        n_res.mem_data     = 8'd0;
        n_res.tick_done    = 1'b1;
        n_res.committed    = 1'b0;
        n_res.ready_valid  = r_ready;
        n_res.ready_bank   = r_bank;
        n_res.ready_size   = r_total;
        n_res.resync_total = r_resync;
        n_res.tx_cmd       = r_phase ? i_cfg.data_cmd : i_cfg.info_cmd;
        n_res.tx_index     = r_phase ? r_wi : 16'd0;
        case (r_st)
            BS_RUN: begin
                n_res.mem_write = w_wr;
                n_res.mem_bank  = w_wr ? !r_bank : 1'b0;
                n_res.mem_addr  = w_wr ? w_addr[15:0] : 16'd0;
                n_res.mem_data  = w_wr ? i_q_item.byte_value : 8'd0;
                n_res.tick_done = w_tick;
                if (w_commit || w_resync) begin
                    n_res.tx_cmd   = i_cfg.info_cmd;
                    n_res.tx_index = 16'd0;
                end else if (w_data_ok) begin
                    n_res.tx_index = w_wi_inc;
                end
                n_res.committed    = w_commit;
                n_res.ready_valid  = r_ready || w_commit;
                n_res.ready_bank   = r_bank ^ w_commit;
                n_res.resync_total = (w_resync && r_resync != 16'hFFFF) ?
                                     r_resync + 16'd1 : r_resync;
            end
            BS_FIN: begin
                n_res.tx_cmd     = i_cfg.data_cmd;
                n_res.tx_index   = 16'd0;
                n_res.ready_size = (w_tot > {16'd0, w_cap}) ? w_cap : w_tot[16:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= BS_RUN;
            r_out_valid <= 1'b0;
            r_phase     <= 1'b0;
            r_ready     <= 1'b0;
            r_bank      <= 1'b0;
            r_cb        <= 16'd0;
            r_cc        <= 16'd0;
            r_tb        <= 16'd0;
            r_wi        <= 16'd0;
            r_pos       <= 16'd0;
            r_total     <= 17'd0;
            r_base      <= 17'd0;
            r_stall     <= 8'd0;
            r_resync    <= 16'd0;
            r_hdr       <= 48'd0;
        end else begin
            r_st        <= n_st;
            r_out_valid <= n_out_valid;
            case (r_st)
                BS_RUN: begin
                    if (w_fire) begin
                        r_hdr <= w_hdr;
                        if (!i_q_item.op || i_q_item.byte_last) r_pos <= 16'd0;
                        else if (r_pos != 16'hFFFF)             r_pos <= r_pos + 16'd1;
                        if (w_info_go) begin
                            r_cb <= w_cb0;
                        end else begin
                            r_resync    <= n_res.resync_total;
                            r_ready     <= n_res.ready_valid;
                            r_bank      <= n_res.ready_bank;
                            if (w_data_ok) begin
                                r_stall <= 8'd0;
                                if (w_commit) begin
                                    r_wi    <= 16'd0;
                                    r_base  <= 17'd0;
                                    r_phase <= 1'b0;
                                end else begin
                                    r_wi   <= w_wi_inc;
                                    r_base <= w_base_inc[17] ? 17'h1FFFF : w_base_inc[16:0];
                                end
                            end else if (w_tick) begin
                                if (w_resync) begin
                                    r_stall <= 8'd0;
                                    r_wi    <= 16'd0;
                                    r_base  <= 17'd0;
                                    r_phase <= 1'b0;
                                end else begin
                                    r_stall <= w_stall1;
                                end
                            end
                        end
                    end
                end
                BS_DIV: begin
                    if (w_div_done) begin
                        r_cc <= w_ccn;
                        r_tb <= w_tbn;
                    end
                end
                BS_FIN: begin
                    if (w_free) begin
                        r_total     <= n_res.ready_size;
                        r_wi        <= 16'd0;
                        r_base      <= 17'd0;
                        r_phase     <= 1'b1;
                        r_stall     <= 8'd0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_st == BS_MUL) begin
            r_prod <= 32'(r_cc - 16'd1) * 32'(r_cb);
        end
        if ((w_fire && !w_info_go) || (r_st == BS_FIN && w_free)) begin
            r_out <= n_res;
        end
    end

endmodule

[src/chunked_fetch_master.sv]
// ----------------------------------------------------------------------------
// chunked_fetch_master: master side of a chunked fetch
// requests an info frame, fetches chunks by index into an assembly bank and
// commits by swapping banks, with a stall watchdog that resyncs
// ----------------------------------------------------------------------------
//  channel   handshake                  payload
//  input     i_in_valid / o_in_stall    i_op i_frame_cmd i_frame_len i_byte_value i_byte_last
//  output    o_out_valid / i_out_stall  o_mem_* o_tick_done o_tx_* o_committed o_ready_*
//  config    psel penable pwrite pready paddr pwdata prdata (apb, 4 registers)
//
//  one item per cycle from the queue to the result register while the output is not stalled and
//  the sequencer runs; an info frame's last byte holds the sequencer through issue, the
//  17-step divider, done, multiply and total; its result is loaded in the total step
//  reset is synchronous, active low; no clearing pass
//  a two-entry queue parts the input from the sequencer; the result register
//  holds while valid and i_out_stall is high, and the next item waits in the queue
// ----------------------------------------------------------------------------
module chunked_fetch_master (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_op,
    input  logic [7:0]  i_frame_cmd,
    input  logic [15:0] i_frame_len,
    input  logic [7:0]  i_byte_value,
    input  logic        i_byte_last,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_mem_write,
    output logic        o_mem_bank,
    output logic [15:0] o_mem_addr,
    output logic [7:0]  o_mem_data,
    output logic        o_tick_done,
    output logic [7:0]  o_tx_cmd,
    output logic [15:0] o_tx_index,
    output logic        o_committed,
    output logic        o_ready_valid,
    output logic        o_ready_bank,
    output logic [16:0] o_ready_size,
    output logic [15:0] o_resync_total,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import cfm_pkg::*;

    t_cfg    r_cfg;
    logic    w_q_valid, w_q_pop;
    t_item   w_q_item;
    t_result w_res;

    // configuration registers, written in the apb access phase
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.capacity  <= RST_CAPACITY;
            r_cfg.threshold <= RST_THRESHOLD;
            r_cfg.info_cmd  <= RST_INFO_CMD;
            r_cfg.data_cmd  <= RST_DATA_CMD;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_CAPACITY:  r_cfg.capacity  <= pwdata[16:0];
                REG_THRESHOLD: r_cfg.threshold <= pwdata[7:0];
                REG_INFO_CMD:  r_cfg.info_cmd  <= pwdata[7:0];
                REG_DATA_CMD:  r_cfg.data_cmd  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_CAPACITY:  prdata = {15'd0, r_cfg.capacity};
            REG_THRESHOLD: prdata = {24'd0, r_cfg.threshold};
            REG_INFO_CMD:  prdata = {24'd0, r_cfg.info_cmd};
            REG_DATA_CMD:  prdata = {24'd0, r_cfg.data_cmd};
            default:       prdata = 32'd0;
        endcase
    end

    // front: accept and queue transactions
    cfm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_op         (i_op),
        .i_frame_cmd  (i_frame_cmd),
        .i_frame_len  (i_frame_len),
        .i_byte_value (i_byte_value),
        .i_byte_last  (i_byte_last),
        .o_q_valid    (w_q_valid),
        .o_q_item     (w_q_item),
        .i_q_pop      (w_q_pop)
    );

    // back: protocol sequencer and result register
    cfm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (w_q_valid),
        .i_q_item    (w_q_item),
        .o_q_pop     (w_q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_res       (w_res)
    );

    assign o_mem_write    = w_res.mem_write;
    assign o_mem_bank     = w_res.mem_bank;
    assign o_mem_addr     = w_res.mem_addr;
    assign o_mem_data     = w_res.mem_data;
    assign o_tick_done    = w_res.tick_done;
    assign o_tx_cmd       = w_res.tx_cmd;
    assign o_tx_index     = w_res.tx_index;
    assign o_committed    = w_res.committed;
    assign o_ready_valid  = w_res.ready_valid;
    assign o_ready_bank   = w_res.ready_bank;
    assign o_ready_size   = w_res.ready_size;
    assign o_resync_total = w_res.resync_total;

    // a commit only happens on a completed tick and marks data ready
    a_commit_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_committed |-> o_tick_done && o_ready_valid)
        else $error("commit without tick or ready flag");

    // write fields are zero when nothing is written
    a_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_mem_write |-> o_mem_addr == 16'd0 && o_mem_data == 8'd0)
        else $error("write fields set without a write");

    // a commit flips the ready bank
    a_commit_swap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall ##1 o_out_valid && o_committed |->
        o_ready_bank != $past(o_ready_bank))
        else $error("commit did not swap banks");

endmodule
